/* rtl/tpwsm_pkg.sv */
// ----------------------------------------------------------------------------
// tpwsm_pkg
// Shared types and constants for the three-port wait-state memory.
// ----------------------------------------------------------------------------
package tpwsm_pkg;

    localparam int NPORTS    = 3;
    localparam int PORT_BITS = 2;
    localparam int FADDR_W   = 16;   // address field width
    localparam int WORD_W    = 32;
    localparam int CNT_W     = 4;
    localparam int IN_DATA_W = 48;
    localparam int IN_USER_W = 5;
    localparam int OUT_W     = 104;

    localparam logic [CNT_W-1:0] WAIT_RESET    = 4'd9;
    localparam logic [CNT_W-1:0] STARTUP_RESET = 4'd10;
    localparam int               INST_OFFSET   = 4;

    // configuration register indexes
    localparam logic CFG_WAIT    = 1'b0;
    localparam logic CFG_STARTUP = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_POST  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_LOAD  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [PORT_BITS-1:0] port;
        logic                 port_ok;   // port names a real port
        logic [FADDR_W-1:0]   address;
        logic [WORD_W-1:0]    data;
        logic                 write;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PORT,
        ST_READ,
        ST_RESULT
    } back_state_t;

endpackage

/* rtl/three_port_wait_state_memory.sv */
// Post, clear, load and startup ticks go from acceptance to ST_RESULT and then
// to the registered output; a servicing tick takes 3 port steps in ST_PORT plus
// an ST_READ step per completing read before ST_RESULT. The back end runs one
// item at a time, and an output stall holds it in ST_RESULT. A 2-entry command
// queue takes new items meanwhile. Synchronous active-low reset clears port
// state and loads the register defaults; the byte store is not cleared.
// ----------------------------------------------------------------------------
// three_port_wait_state_memory
// Byte-addressed memory shared by a data port and two instruction ports.
// ----------------------------------------------------------------------------
module three_port_wait_state_memory
    import tpwsm_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,  // address[15:0], data_in[47:16]
    input  logic [IN_USER_W-1:0] s_tuser,  // op[1:0], port[3:2], write[4]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // done_mask[2:0], busy_mask[5:3], read_data_port[37:6],
    // read_data_inst_one[69:38], read_data_inst_two[101:70], started[102]
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    tpwsm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    tpwsm_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/tpwsm_front.sv */
// ----------------------------------------------------------------------------
// tpwsm_front
// Accepts input transactions, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module tpwsm_front
    import tpwsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [IN_USER_W-1:0] s_tuser,
    output logic                 q_valid,
    output cmd_t                 q_cmd,
    input  logic                 q_pop
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       dec_cmd;
    logic       push;
    logic       pop;

    always_comb begin
        dec_cmd.op      = op_t'(s_tuser[1:0]);
        dec_cmd.port    = s_tuser[3:2];
        dec_cmd.port_ok = (s_tuser[3:2] != PORT_BITS'(NPORTS));
        dec_cmd.address = s_tdata[FADDR_W-1:0];
        dec_cmd.data    = s_tdata[FADDR_W +: WORD_W];
        dec_cmd.write   = s_tuser[4];
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

/* rtl/tpwsm_back.sv */
// ----------------------------------------------------------------------------
// tpwsm_back
// Executes queued commands: port state, wait counters, byte store, result.
// ----------------------------------------------------------------------------
module tpwsm_back
    import tpwsm_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CNT_W-1:0] cfg_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int ROW_BITS = ADDR_BITS - 2;

    back_state_t          state_reg, state_next;
    logic [PORT_BITS-1:0] pidx_reg, pidx_next;
    logic [FADDR_W-1:0]   paddr_reg [NPORTS];
    logic [FADDR_W-1:0]   paddr_next [NPORTS];
    logic [WORD_W-1:0]    pword_reg [NPORTS];
    logic [WORD_W-1:0]    pword_next [NPORTS];
    logic                 pwr_reg [NPORTS];
    logic                 pwr_next [NPORTS];
    logic                 pdone_reg [NPORTS];
    logic                 pdone_next [NPORTS];
    logic [CNT_W-1:0]     pcnt_reg [NPORTS];
    logic [CNT_W-1:0]     pcnt_next [NPORTS];
    logic [CNT_W-1:0]     start_cnt_reg, start_cnt_next;
    logic [CNT_W-1:0]     wait_reg, wait_next;
    logic [1:0]           lane_reg, lane_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]     m_data_reg, m_data_next;

    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [ROW_BITS-1:0]  row [4];
    logic [7:0]           wbyte [4];
    logic [7:0]           rdata_q [4];
    logic [WORD_W-1:0]    rword;

    logic [ADDR_BITS-1:0] acc_addr;
    logic                 last_port;
    logic [NPORTS-1:0]    done_mask;
    logic [NPORTS-1:0]    busy_mask;

    assign last_port = (pidx_reg == PORT_BITS'(NPORTS - 1));

    // byte address of the current port's access; instruction ports sit 4 below
    always_comb begin
        acc_addr = ADDR_BITS'(paddr_reg[pidx_reg]);
        if (pidx_reg != '0) begin
            acc_addr = acc_addr - ADDR_BITS'(INST_OFFSET);
        end
    end

    always_comb begin
        for (int p = 0; p < NPORTS; p++) begin
            done_mask[p] = pdone_reg[p];
            busy_mask[p] = !pdone_reg[p] && (paddr_reg[p] != '0);
        end
    end

    // word assembled from the four byte lanes, lowest byte at the access address
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rword[8*k +: 8] = rdata_q[2'(k) + lane_reg];
        end
    end

    always_comb begin
        state_next     = state_reg;
        pidx_next      = pidx_reg;
        paddr_next     = paddr_reg;
        pword_next     = pword_reg;
        pwr_next       = pwr_reg;
        pdone_next     = pdone_reg;
        pcnt_next      = pcnt_reg;
        start_cnt_next = start_cnt_reg;
        wait_next      = wait_reg;
        lane_next      = lane_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = acc_addr;
        mem_wdata      = pword_reg[pidx_reg];

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_WAIT: begin
                    wait_next = cfg_data;
                end
                CFG_STARTUP: begin
                    start_cnt_next = cfg_data;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = ST_RESULT;
                    case (q_cmd.op)
                        OP_TICK: begin
                            if (start_cnt_reg != '0) begin
                                start_cnt_next = start_cnt_reg - CNT_W'(1);
                            end else begin
                                pidx_next  = '0;
                                state_next = ST_PORT;
                            end
                        end
                        OP_POST: begin
                            if (q_cmd.port_ok) begin
                                paddr_next[q_cmd.port] = q_cmd.address;
                                pword_next[q_cmd.port] = q_cmd.data;
                                pwr_next[q_cmd.port]   = q_cmd.write;
                            end
                        end
                        OP_CLEAR: begin
                            if (q_cmd.port_ok) begin
                                pdone_next[q_cmd.port] = 1'b0;
                            end
                        end
                        default: begin
                            mem_we    = 1'b1;
                            mem_addr  = ADDR_BITS'(q_cmd.address);
                            mem_wdata = q_cmd.data;
                        end
                    endcase
                end
            end
            ST_PORT: begin
                if (last_port) begin
                    state_next = ST_RESULT;
                end else begin
                    pidx_next = pidx_reg + PORT_BITS'(1);
                end
                if (paddr_reg[pidx_reg] != '0 && !pdone_reg[pidx_reg]) begin
                    if (pcnt_reg[pidx_reg] == '0) begin
                        pcnt_next[pidx_reg] = wait_reg;
                    end else begin
                        pcnt_next[pidx_reg] = pcnt_reg[pidx_reg] - CNT_W'(1);
                        if (pcnt_reg[pidx_reg] == CNT_W'(1)) begin
                            if (pwr_reg[pidx_reg]) begin
                                mem_we               = 1'b1;
                                paddr_next[pidx_reg] = '0;
                                pword_next[pidx_reg] = '0;
                                pwr_next[pidx_reg]   = 1'b0;
                                pdone_next[pidx_reg] = 1'b1;
                            end else begin
                                mem_re     = 1'b1;
                                lane_next  = acc_addr[1:0];
                                pidx_next  = pidx_reg;
                                state_next = ST_READ;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                pword_next[pidx_reg] = rword;
                pdone_next[pidx_reg] = 1'b1;
                if (last_port) begin
                    state_next = ST_RESULT;
                end else begin
                    pidx_next  = pidx_reg + PORT_BITS'(1);
                    state_next = ST_PORT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, (start_cnt_reg == '0),
                                    pword_reg[2], pword_reg[1], pword_reg[0],
                                    busy_mask, done_mask};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pidx_reg      <= '0;
            start_cnt_reg <= STARTUP_RESET;
            wait_reg      <= WAIT_RESET;
            lane_reg      <= '0;
            m_valid_reg   <= 1'b0;
            for (int p = 0; p < NPORTS; p++) begin
                paddr_reg[p] <= '0;
                pword_reg[p] <= '0;
                pwr_reg[p]   <= 1'b0;
                pdone_reg[p] <= 1'b0;
                pcnt_reg[p]  <= '0;
            end
        end else begin
            state_reg     <= state_next;
            pidx_reg      <= pidx_next;
            start_cnt_reg <= start_cnt_next;
            wait_reg      <= wait_next;
            lane_reg      <= lane_next;
            m_valid_reg   <= m_valid_next;
            paddr_reg     <= paddr_next;
            pword_reg     <= pword_next;
            pwr_reg       <= pwr_next;
            pdone_reg     <= pdone_next;
            pcnt_reg      <= pcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // four byte lanes; an unaligned word touches each lane once
    always_comb begin
        logic [1:0]           k;
        logic [ADDR_BITS-1:0] baddr;
        for (int l = 0; l < 4; l++) begin
            k        = 2'(l) - mem_addr[1:0];
            baddr    = mem_addr + ADDR_BITS'(k);
            row[l]   = baddr[ADDR_BITS-1:2];
            wbyte[l] = mem_wdata[{k, 3'b000} +: 8];
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_bank
        logic [7:0] bank_mem [2**ROW_BITS];

        always_ff @(posedge aclk) begin
            if (mem_we) begin
                bank_mem[row[l]] <= wbyte[l];
            end
            if (mem_re) begin
                rdata_q[l] <= bank_mem[row[l]];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
